// File: src/sorted_edge_symmetrizer_defines.svh
// ----------------------------------------------------------------------------
// sorted_edge_symmetrizer_defines
// assertion macros shared by the edge symmetrizer modules
// ----------------------------------------------------------------------------
`ifndef SORTED_EDGE_SYMMETRIZER_DEFINES_SVH
`define SORTED_EDGE_SYMMETRIZER_DEFINES_SVH

// property checked on every clock edge outside reset
`define SES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must hold in the cycle after a trigger
`define SES_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// File: src/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// types, constants and helpers of the sorted edge symmetrizer
// ----------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

  // queue and identifier geometry
  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned NODE_BITS   = 32;
  localparam int unsigned KEY_BITS    = 2 * ID_BITS;
  localparam int unsigned W_BITS      = 34;

  // weight generator
  localparam logic [W_BITS-1:0] LFSR_TAPS  = 34'h204000003;
  localparam logic [W_BITS-1:0] LFSR_RESET = 34'h204000003;

  typedef enum logic [1:0] {
    STAT_PAIR = 2'd0,
    STAT_LOOP = 2'd1,
    STAT_DROP = 2'd2
  } ses_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EDGE,
    ST_FLUSH
  } ses_state_e;

  // one queue slot
  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
  } ses_slot_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                pop;
    logic                push;
    logic [KEY_BITS-1:0] key;
  } ses_qcmd_t;

  // queue status seen by the controller
  typedef struct packed {
    ses_slot_t head;
    ses_slot_t second;
    logic      full;
  } ses_qstat_t;

  // galois lfsr step
  function automatic logic [W_BITS-1:0] lfsr_next(input logic [W_BITS-1:0] s);
    logic [W_BITS-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/sorted_edge_symmetrizer.sv
// sequence: an edge item is accepted, then each held key whose turn has come is popped, then the edge is handled;
//   its first result is registered and shows in the cycle after it is produced
// flow: no new item is taken until the current edge or flush item is done (in_stall_o high),
//   and the queue chain does one pop or push per cycle while the output is not stalled
// reset: queue empties at once (valid bits per cell), weight = successor of seed 1
// ----------------------------------------------------------------------------
// sorted_edge_symmetrizer
// turns a sorted directed edge stream into weighted undirected edge pairs,
// holding reversed forward edges in a sorted queue until their turn comes
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_edge_symmetrizer_defines.svh"

module sorted_edge_symmetrizer
  import ses_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [W_BITS-1:0]    weight_seed_i,
  // input items
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [NODE_BITS-1:0] src_node_i,
  input  wire logic [NODE_BITS-1:0] dst_node_i,
  // result items
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [NODE_BITS-1:0]      first_src_o,
  output logic [NODE_BITS-1:0]      first_dst_o,
  output logic [NODE_BITS-1:0]      second_src_o,
  output logic [NODE_BITS-1:0]      second_dst_o,
  output logic [W_BITS-1:0]         edge_weight_o,
  output logic                      last_o
);

  ses_state_e state_q, state_d;
  logic       keep_q, keep_d;
  logic [ID_BITS-1:0] src_q, dst_q;
  logic [W_BITS-1:0]  lfsr_q;

  logic out_valid_q, out_valid_d;
  logic [1:0] status_q, status_d;
  logic [NODE_BITS-1:0] fsrc_q, fsrc_d, fdst_q, fdst_d, ssrc_q, ssrc_d, sdst_q, sdst_d;
  logic [W_BITS-1:0] weight_q, weight_d;
  logic last_q, last_d;

  ses_qcmd_t  qcmd;
  ses_qstat_t qstat;

  logic in_acc, cfg_we, out_free, emit, lfsr_adv;
  logic [KEY_BITS-1:0] ukey;
  logic [ID_BITS-1:0]  head_a, head_b;
  logic head_le, head_hit, next_le, own_res;

  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // head compare against the current edge
  assign ukey     = {src_q, dst_q};
  assign head_a   = qstat.head.key[KEY_BITS-1:ID_BITS];
  assign head_b   = qstat.head.key[ID_BITS-1:0];
  assign head_le  = qstat.head.valid && (qstat.head.key <= ukey);
  assign head_hit = (qstat.head.key == ukey);
  assign next_le  = qstat.second.valid && (qstat.second.key <= ukey);
  assign own_res  = keep_q && !head_hit && (src_q >= dst_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    keep_d      = keep_q;
    qcmd.pop    = 1'b0;
    qcmd.push   = 1'b0;
    qcmd.key    = {dst_q, src_q};
    emit        = 1'b0;
    lfsr_adv    = 1'b0;
    status_d    = status_q;
    fsrc_d      = fsrc_q;
    fdst_d      = fdst_q;
    ssrc_d      = ssrc_q;
    sdst_d      = sdst_q;
    weight_d    = weight_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          keep_d  = 1'b1;
          state_d = operation_i ? ST_FLUSH : ST_EDGE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (qstat.head.valid) begin
            emit     = 1'b1;
            lfsr_adv = 1'b1;
            qcmd.pop = 1'b1;
            status_d = STAT_PAIR;
            fsrc_d   = NODE_BITS'(head_b);
            fdst_d   = NODE_BITS'(head_a);
            ssrc_d   = NODE_BITS'(head_a);
            sdst_d   = NODE_BITS'(head_b);
            weight_d = lfsr_q;
            last_d   = !qstat.second.valid;
            if (!qstat.second.valid) begin
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EDGE: begin
        if (out_free) begin
          if (head_le) begin
            // pop a held key whose turn has come
            emit     = 1'b1;
            lfsr_adv = 1'b1;
            qcmd.pop = 1'b1;
            keep_d   = keep_q && !head_hit;
            status_d = STAT_PAIR;
            fsrc_d   = NODE_BITS'(head_b);
            fdst_d   = NODE_BITS'(head_a);
            ssrc_d   = NODE_BITS'(head_a);
            sdst_d   = NODE_BITS'(head_b);
            weight_d = lfsr_q;
            last_d   = !next_le && !own_res;
          end else begin
            // the edge itself
            state_d = ST_IDLE;
            fsrc_d  = NODE_BITS'(src_q);
            fdst_d  = NODE_BITS'(dst_q);
            ssrc_d  = NODE_BITS'(dst_q);
            sdst_d  = NODE_BITS'(src_q);
            last_d  = 1'b1;
            if (keep_q) begin
              priority if (src_q == dst_q) begin
                emit     = 1'b1;
                lfsr_adv = 1'b1;
                status_d = STAT_LOOP;
                ssrc_d   = NODE_BITS'(src_q);
                sdst_d   = NODE_BITS'(dst_q);
                weight_d = lfsr_q;
              end else if (src_q > dst_q) begin
                emit     = 1'b1;
                lfsr_adv = 1'b1;
                status_d = STAT_PAIR;
                weight_d = lfsr_q;
              end else if (qstat.full) begin
                emit     = 1'b1;
                status_d = STAT_DROP;
                weight_d = '0;
              end else begin
                qcmd.push = 1'b1;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= 1'b0;
      out_valid_q <= 1'b0;
      lfsr_q      <= LFSR_RESET;
    end else begin
      state_q     <= state_d;
      keep_q      <= keep_d;
      out_valid_q <= out_valid_d;
      if (cfg_we) begin
        lfsr_q <= lfsr_next(weight_seed_i);
      end else if (lfsr_adv) begin
        lfsr_q <= lfsr_next(lfsr_q);
      end
    end
  end

  // edge and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      src_q <= src_node_i[ID_BITS-1:0];
      dst_q <= dst_node_i[ID_BITS-1:0];
    end
    status_q <= status_d;
    fsrc_q   <= fsrc_d;
    fdst_q   <= fdst_d;
    ssrc_q   <= ssrc_d;
    sdst_q   <= sdst_d;
    weight_q <= weight_d;
    last_q   <= last_d;
  end

  // sorted queue
  ses_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (qcmd),
    .stat_o (qstat)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign first_src_o   = fsrc_q;
  assign first_dst_o   = fdst_q;
  assign second_src_o  = ssrc_q;
  assign second_dst_o  = sdst_q;
  assign edge_weight_o = weight_q;
  assign last_o        = last_q;

  `SES_ASSERT(a_push_room, qcmd.push |-> !qstat.full, "push into full queue")
  `SES_ASSERT(a_drop_weight, (out_valid_o && (status_o == STAT_DROP)) |-> (edge_weight_o == '0), "drop with weight")
  `SES_ASSERT_NEXT(a_acc_busy, in_acc, (state_q != ST_IDLE), "accepted transaction not in work")

endmodule

`default_nettype wire

// File: src/ses_cell.sv
// ----------------------------------------------------------------------------
// ses_cell
// one slot of the sorted queue: shifts toward the head on pop, makes room
// and takes the new key on push
// ----------------------------------------------------------------------------
`default_nettype none

module ses_cell
  import ses_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ses_qcmd_t cmd_i,
  input  wire ses_slot_t prev_slot_i,
  input  wire logic      prev_gt_i,
  input  wire ses_slot_t next_slot_i,
  output ses_slot_t      slot_o,
  output logic           gt_o
);

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;

  // empty slot counts as larger than any key
  assign gt_o   = !valid_q || (key_q > cmd_i.key);
  assign slot_o = '{valid: valid_q, key: key_q};

  // next slot content
  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    if (cmd_i.pop) begin
      valid_d = next_slot_i.valid;
      key_d   = next_slot_i.key;
    end else if (cmd_i.push && gt_o) begin
      if (prev_gt_i) begin
        valid_d = prev_slot_i.valid;
        key_d   = prev_slot_i.key;
      end else begin
        valid_d = 1'b1;
        key_d   = cmd_i.key;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

`default_nettype wire

// File: src/ses_queue.sv
// ----------------------------------------------------------------------------
// ses_queue
// sorted min-queue built as a chain of cells, smallest key in cell zero
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_edge_symmetrizer_defines.svh"

module ses_queue
  import ses_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ses_qcmd_t cmd_i,
  output ses_qstat_t     stat_o
);

  ses_slot_t slot_w [QUEUE_DEPTH];
  logic      gt_w   [QUEUE_DEPTH];

  // chain of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    ses_slot_t prev_slot;
    logic      prev_gt;
    ses_slot_t next_slot;

    if (i == 0) begin : g_first
      assign prev_slot = '0;
      assign prev_gt   = 1'b0;
    end else begin : g_mid
      assign prev_slot = slot_w[i-1];
      assign prev_gt   = gt_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_slot = '0;
    end else begin : g_inner
      assign next_slot = slot_w[i+1];
    end

    ses_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .prev_slot_i (prev_slot),
      .prev_gt_i   (prev_gt),
      .next_slot_i (next_slot),
      .slot_o      (slot_w[i]),
      .gt_o        (gt_w[i])
    );
  end

  // status toward the controller
  assign stat_o.head   = slot_w[0];
  assign stat_o.second = slot_w[1];
  assign stat_o.full   = slot_w[QUEUE_DEPTH-1].valid;

  // occupied slots stay packed at the head and in ascending order
  for (genvar j = 0; j < QUEUE_DEPTH - 1; j++) begin : g_chk
    `SES_ASSERT(a_packed, slot_w[j+1].valid |-> slot_w[j].valid, "queue has a hole")
    `SES_ASSERT(a_sorted, slot_w[j+1].valid |-> (slot_w[j].key <= slot_w[j+1].key), "queue unsorted")
  end
  `SES_ASSERT(a_one_op, !(cmd_i.pop && cmd_i.push), "push and pop in one cycle")

endmodule

`default_nettype wire

// File: tb/edge_pair_tracker_pkg.sv
// ----------------------------------------------------------------------------
// edge_pair_tracker_pkg
// expected edge pairs of the sorted edge symmetrizer: a shadow of the pending
// key queue and the weight generator, fed by accepted input transactions and
// checked against every accepted result transaction
// ----------------------------------------------------------------------------
package edge_pair_tracker_pkg;

  import ses_pkg::*;

  // what an input transaction asks for
  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_FLUSH = 1'b1
  } edge_op_e;

  // one result transaction as the block should produce it
  typedef struct packed {
    ses_status_e          status;
    logic [NODE_BITS-1:0] first_src;
    logic [NODE_BITS-1:0] first_dst;
    logic [NODE_BITS-1:0] second_src;
    logic [NODE_BITS-1:0] second_dst;
    logic [W_BITS-1:0]    weight;
    logic                 last;
  } edge_pair_t;

  // keep the log short if the block is badly off
  localparam int unsigned MAX_PRINTED = 30;

  class edge_pair_tracker;
    logic [KEY_BITS-1:0] held_keys[$];   // reversed forward edges, ascending
    logic [W_BITS-1:0]   weight;
    edge_pair_t          pairs_due[$];
    edge_pair_t          batch[$];       // results of the transaction at hand
    int unsigned         errors;

    function new();
      weight = lfsr_advance(W_BITS'(1));
      errors = 0;
    endfunction

    // galois step, taps from the package
    function logic [W_BITS-1:0] lfsr_advance(input logic [W_BITS-1:0] s);
      return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
    endfunction

    function void load_seed(input logic [W_BITS-1:0] seed);
      weight = lfsr_advance(seed);
    endfunction

    function void emit(input ses_status_e st, input logic [NODE_BITS-1:0] fs,
                       input logic [NODE_BITS-1:0] fd, input logic [NODE_BITS-1:0] ss,
                       input logic [NODE_BITS-1:0] sd, input logic [W_BITS-1:0] w);
      edge_pair_t r;
      r.status     = st;
      r.first_src  = fs;
      r.first_dst  = fd;
      r.second_src = ss;
      r.second_dst = sd;
      r.weight     = w;
      r.last       = 1'b0;
      batch.push_back(r);
    endfunction

    // smallest key leaves the queue as a weighted pair
    function void pop_smallest();
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  a;
      logic [ID_BITS-1:0]  b;
      key = held_keys.pop_front();
      a   = key[KEY_BITS-1:ID_BITS];
      b   = key[ID_BITS-1:0];
      emit(STAT_PAIR, b, a, a, b, weight);
      weight = lfsr_advance(weight);
    endfunction

    // sorted insert, equal keys stay in arrival order
    function void hold_key(input logic [KEY_BITS-1:0] key);
      int i;
      i = held_keys.size();
      while (i > 0 && held_keys[i-1] > key) begin
        i--;
      end
      held_keys.insert(i, key);
    endfunction

    // expected results of one accepted input transaction
    function void absorb_item(input edge_op_e op, input logic [NODE_BITS-1:0] src_in,
                              input logic [NODE_BITS-1:0] dst_in);
      logic [ID_BITS-1:0]  src;
      logic [ID_BITS-1:0]  dst;
      logic [KEY_BITS-1:0] key;
      edge_pair_t          r;
      bit                  keep;
      src  = src_in[ID_BITS-1:0];
      dst  = dst_in[ID_BITS-1:0];
      key  = {src, dst};
      keep = 1'b1;
      batch.delete();
      if (op == OP_FLUSH) begin
        while (held_keys.size() != 0) begin
          pop_smallest();
        end
      end else begin
        // drain every key up to this edge; an equal key means the pair is done
        while (held_keys.size() != 0 && held_keys[0] <= key) begin
          if (held_keys[0] == key) begin
            keep = 1'b0;
          end
          pop_smallest();
        end
        if (keep) begin
          if (src == dst) begin
            emit(STAT_LOOP, src, dst, src, dst, weight);
            weight = lfsr_advance(weight);
          end else if (src > dst) begin
            emit(STAT_PAIR, src, dst, dst, src, weight);
            weight = lfsr_advance(weight);
          end else if (held_keys.size() < QUEUE_DEPTH) begin
            hold_key({dst, src});
          end else begin
            // queue full: dropped, weight untouched
            emit(STAT_DROP, src, dst, dst, src, '0);
          end
        end
      end
      if (batch.size() != 0) begin
        r = batch.pop_back();
        r.last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) begin
        pairs_due.push_back(batch[i]);
      end
    endfunction

    task report(input string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("mismatch: %s", what);
      end
    endtask

    // compare one accepted result transaction with the oldest expectation
    task match_pair(input logic [1:0] st, input logic [NODE_BITS-1:0] fs,
                    input logic [NODE_BITS-1:0] fd, input logic [NODE_BITS-1:0] ss,
                    input logic [NODE_BITS-1:0] sd, input logic [W_BITS-1:0] w,
                    input logic lst);
      edge_pair_t want;
      if (pairs_due.size() == 0) begin
        report($sformatf("unexpected result status %0d edge %h->%h", st, fs, fd));
        return;
      end
      want = pairs_due.pop_front();
      if (st !== want.status) begin
        report($sformatf("status %0d, expected %0d", st, want.status));
      end
      if (fs !== want.first_src) begin
        report($sformatf("first_src %h, expected %h", fs, want.first_src));
      end
      if (fd !== want.first_dst) begin
        report($sformatf("first_dst %h, expected %h", fd, want.first_dst));
      end
      if (ss !== want.second_src) begin
        report($sformatf("second_src %h, expected %h", ss, want.second_src));
      end
      if (sd !== want.second_dst) begin
        report($sformatf("second_dst %h, expected %h", sd, want.second_dst));
      end
      if (w !== want.weight) begin
        report($sformatf("edge_weight %h, expected %h", w, want.weight));
      end
      if (lst !== want.last) begin
        report($sformatf("last %b, expected %b", lst, want.last));
      end
    endtask
  endclass

endpackage

// File: tb/sorted_edge_symmetrizer_test.sv
// ----------------------------------------------------------------------------
// sorted_edge_symmetrizer_test
// drives directed and sorted random edge streams with flushes, random gaps
// and output stalls through the symmetrizer, predicts every weighted pair and
// compares each result transaction field by field
// ----------------------------------------------------------------------------
module sorted_edge_symmetrizer_test;

  import ses_pkg::*;
  import edge_pair_tracker_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 60;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 40;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [W_BITS-1:0]    weight_seed_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 operation_i;
  logic [NODE_BITS-1:0] src_node_i;
  logic [NODE_BITS-1:0] dst_node_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic [NODE_BITS-1:0] first_src_o;
  logic [NODE_BITS-1:0] first_dst_o;
  logic [NODE_BITS-1:0] second_src_o;
  logic [NODE_BITS-1:0] second_dst_o;
  logic [W_BITS-1:0]    edge_weight_o;
  logic                 last_o;

  edge_pair_tracker tracker;
  int unsigned      cycle_count = 0;
  int unsigned      items_sent  = 0;
  bit               tx_quiet    = 1'b0;
  bit               rx_quiet    = 1'b0;
  bit               hold_req    = 1'b0;
  int unsigned      hold_left   = 0;
  int unsigned      rx_wait     = 0;

  sorted_edge_symmetrizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .weight_seed_i (weight_seed_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .src_node_i    (src_node_i),
    .dst_node_i    (dst_node_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .first_src_o   (first_src_o),
    .first_dst_o   (first_dst_o),
    .second_src_o  (second_src_o),
    .second_dst_o  (second_dst_o),
    .edge_weight_o (edge_weight_o),
    .last_o        (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: long hold-off on request, else a drawn wait per result
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (rx_wait != 0) begin
      out_stall_i <= 1'b1;
      rx_wait--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.match_pair(status_o, first_src_o, first_dst_o, second_src_o, second_dst_o,
                         edge_weight_o, last_o);
      rx_wait = rx_quiet ? 0 : $urandom_range(16, 0);
      if ($urandom_range(39, 0) == 0) begin
        rx_quiet = !rx_quiet;
      end
    end
  end

  // one input transaction, after a drawn gap
  task automatic send_item(input edge_op_e op, input logic [NODE_BITS-1:0] src,
                           input logic [NODE_BITS-1:0] dst);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(16, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    src_node_i  <= src;
    dst_node_i  <= dst;
    do @(posedge clk_i); while (in_stall_o);
    tracker.absorb_item(op, src, dst);
    items_sent++;
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.pairs_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [W_BITS-1:0] seed);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    weight_seed_i <= seed;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.load_seed(seed);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // extremes, loops and pairs, suppression, duplicates, flushes, unsorted order
  task automatic run_directed();
    send_item(OP_EDGE, 32'h0, 32'h0);
    send_item(OP_EDGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'd5, 32'd3);
    send_item(OP_EDGE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_EDGE, 32'd1, 32'd7);
    send_item(OP_EDGE, 32'd1, 32'd7);
    send_item(OP_EDGE, 32'd2, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'd3, 32'd9);
    send_item(OP_EDGE, 32'd7, 32'd1);
    send_item(OP_EDGE, 32'd8, 32'd8);
    send_item(OP_EDGE, 32'd9, 32'd3);
    send_item(OP_FLUSH, 32'h0, 32'h0);
    send_item(OP_FLUSH, 32'h0, 32'h0);
    send_item(OP_EDGE, 32'h0, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 32'hFFFF_FFFF, 32'h0);
    send_item(OP_EDGE, 32'd10, 32'd20);
    send_item(OP_EDGE, 32'd15, 32'd5);
    send_item(OP_EDGE, 32'd20, 32'd10);
    send_item(OP_EDGE, 32'd4, 32'd6);
    send_item(OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // one hub with more forward edges than the queue holds
  task automatic send_fanout(input bit close_with_sweep);
    logic [NODE_BITS-1:0] hub;
    int unsigned          spokes;
    send_item(OP_FLUSH, $urandom, $urandom);
    hub    = $urandom_range(32'hFFFF_FF00, 0);
    spokes = QUEUE_DEPTH + $urandom_range(6, 2);
    for (int unsigned k = 1; k <= spokes; k++) begin
      send_item(OP_EDGE, hub, hub + k);
    end
    // a sweep past every key pops the full queue and adds its own pair
    if (close_with_sweep) begin
      send_item(OP_EDGE, 32'hFFFF_FFFF, 32'h0);
    end else begin
      send_item(OP_FLUSH, $urandom, $urandom);
    end
  endtask

  // small random graph sent in sorted order, mostly symmetric, with some noise
  task automatic send_graph(input int unsigned min_nodes);
    logic [NODE_BITS-1:0] node_id [8];
    bit                   arc [8][8];
    int unsigned          n;
    int unsigned          r;
    n          = $urandom_range(8, min_nodes);
    node_id[0] = $urandom_range(32'hFFFF_FFC0, 0);
    for (int i = 1; i < 8; i++) begin
      node_id[i] = node_id[i-1] + $urandom_range(3, 1);
    end
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        arc[i][j] = 1'b0;
      end
    end
    for (int i = 0; i < 8; i++) begin
      arc[i][i] = ($urandom_range(4, 0) == 0);
      for (int j = i + 1; j < 8; j++) begin
        r = $urandom_range(9, 0);
        arc[i][j] = (r < 7);
        arc[j][i] = (r < 5) || (r == 7) || (r == 8);
      end
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (arc[i][j]) begin
          if ($urandom_range(7, 0) == 0) begin
            send_item(edge_op_e'($urandom_range(1, 0)), $urandom, $urandom);
          end
          send_item(OP_EDGE, node_id[i], node_id[j]);
          if ($urandom_range(11, 0) == 0) begin
            send_item(OP_EDGE, node_id[i], node_id[j]);
          end
        end
      end
    end
    if ($urandom_range(1, 0) == 0) begin
      send_item(OP_FLUSH, $urandom, $urandom);
    end
  endtask

  task automatic run_random(input int unsigned count, input int unsigned phase);
    int unsigned goal;
    bit          paused;
    goal   = items_sent + count;
    paused = 1'b0;
    if (phase == 1) begin
      send_fanout(1'b1);
    end
    // result side holds off while input keeps coming
    if (phase == 2) begin
      tx_quiet = 1'b1;
      hold_req = 1'b1;
      send_graph(8);
    end
    while (items_sent < goal) begin
      tx_quiet = ($urandom_range(3, 0) == 0);
      if (phase == 3 && !paused && items_sent + count / 2 > goal) begin
        settle();
        paused = 1'b1;
        send_fanout(1'b0);
      end
      send_graph(2);
    end
  endtask

  initial begin
    tracker       = new();
    cfg_valid_i   = 1'b0;
    weight_seed_i = '0;
    in_valid_i    = 1'b0;
    operation_i   = 1'b0;
    src_node_i    = '0;
    dst_node_i    = '0;
    out_stall_i   = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset seed first
    run_directed();
    settle();

    // zero seed keeps the weight at zero
    write_seed('0);
    send_item(OP_EDGE, 32'd3, 32'd1);
    send_item(OP_EDGE, 32'd2, 32'd2);
    send_item(OP_EDGE, 32'd1, 32'd4);
    send_item(OP_FLUSH, 32'h0, 32'h0);
    settle();

    write_seed({W_BITS{1'b1}});
    run_random(ITEMS_PER_PHASE, 1);
    settle();

    write_seed({W_BITS'($urandom_range(3, 0)) << 32} | W_BITS'($urandom));
    run_random(ITEMS_PER_PHASE, 2);
    settle();

    write_seed(W_BITS'(1));
    run_random(ITEMS_PER_PHASE, 3);
    settle();

    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/ses_pkg.sv
src/ses_cell.sv
src/ses_queue.sv
src/sorted_edge_symmetrizer.sv
tb/edge_pair_tracker_pkg.sv
tb/sorted_edge_symmetrizer_test.sv
